### hdl/jtnn_pkg.sv
// ----------------------------------------------------------------------------
// jtnn_pkg
// Shared types, widths and codes for the joint tree nearest node block.
// ----------------------------------------------------------------------------
package jtnn_pkg;

    localparam int JOINTS        = 7;
    localparam int JOINT_W       = 16;
    localparam int IDX_W         = 12;
    localparam int SQ_W          = 32;
    localparam int SUM_W         = SQ_W + $clog2(JOINTS);
    localparam int ROOT_W        = (SUM_W + 1) / 2;
    localparam int DIST_W        = 16;
    localparam int COST_W        = 32;
    localparam int DEF_MAX_NODES = 4096;

    typedef logic signed [JOINT_W-1:0] t_joint;
    typedef t_joint [JOINTS-1:0]        t_joint_vec;
    typedef logic [SQ_W-1:0]            t_sq;
    typedef t_sq [JOINTS-1:0]           t_sq_vec;

    localparam logic [1:0] REQ_ROOT   = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_PAR  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COST,
        S_SQRT,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        OP_ROOT,
        OP_INSERT,
        OP_QUERY,
        OP_IMM
    } t_op;

endpackage

### hdl/jtnn_ram.sv
// ----------------------------------------------------------------------------
// jtnn_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module jtnn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/jtnn_lane.sv
// ----------------------------------------------------------------------------
// jtnn_lane
// One joint lane: difference to the query and its registered square.
// ----------------------------------------------------------------------------
module jtnn_lane
    import jtnn_pkg::*;
(
    input  logic   i_clk,
    input  t_joint i_query,
    input  t_joint i_node,
    output t_sq    o_sq
);

    logic signed [JOINT_W:0] diff;
    logic signed [JOINT_W:0] mag;
    logic [JOINT_W-1:0]      mag_u;
    t_sq                     r_sq;

    always_comb begin
        diff  = (JOINT_W+1)'(i_query) - (JOINT_W+1)'(i_node);
        mag   = diff[JOINT_W] ? -diff : diff;
        mag_u = mag[JOINT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_sq <= SQ_W'(mag_u) * SQ_W'(mag_u);
    end

    assign o_sq = r_sq;

endmodule

### hdl/jtnn_merge.sv
// ----------------------------------------------------------------------------
// jtnn_merge
// Sum the lane squares and keep the strictly smallest sum seen so far.
// ----------------------------------------------------------------------------
module jtnn_merge
    import jtnn_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_valid,
    input  logic [AW-1:0]    i_idx,
    input  t_sq_vec          i_sq,
    output logic             o_busy,
    output logic [AW-1:0]    o_best_idx,
    output logic [SUM_W-1:0] o_best_sq
);

    logic [SUM_W-1:0] sum;
    logic             r_valid;
    logic [AW-1:0]    r_idx;
    logic [SUM_W-1:0] r_sum;
    logic             r_have;
    logic [AW-1:0]    r_best_idx;
    logic [SUM_W-1:0] r_best_sq;

    always_comb begin
        sum = '0;
        for (int j = 0; j < JOINTS; j++) begin
            sum = sum + SUM_W'(i_sq[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            r_valid <= i_valid;
            if (i_clear) begin
                r_have <= 1'b0;
            end else if (r_valid) begin
                r_have <= 1'b1;
            end
        end
        r_idx <= i_idx;
        r_sum <= sum;
        // replace only on strictly smaller, so the lowest index wins ties
        if (r_valid && (!r_have || r_sum < r_best_sq)) begin
            r_best_idx <= r_idx;
            r_best_sq  <= r_sum;
        end
    end

    assign o_busy     = r_valid;
    assign o_best_idx = r_best_idx;
    assign o_best_sq  = r_best_sq;

endmodule

### hdl/jtnn_sqrt.sv
// ----------------------------------------------------------------------------
// jtnn_sqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module jtnn_sqrt
    import jtnn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_operand,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] r_x;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic [ROOT_W+3:0]   rem_sh;
    logic [ROOT_W+3:0]   trial;
    logic                take;

    always_comb begin
        rem_sh = {r_rem, r_x[2*ROOT_W-1 -: 2]};
        trial  = (ROOT_W+4)'({r_root, 2'b01});
        take   = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(ROOT_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_start) begin
            r_x    <= (2*ROOT_W)'(i_operand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_x    <= {r_x[2*ROOT_W-3:0], 2'b00};
            r_rem  <= take ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
            r_root <= {r_root[ROOT_W-2:0], take};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_root = r_root;

endmodule

### hdl/joint_tree_nearest_node.sv
// ----------------------------------------------------------------------------
// joint_tree_nearest_node
// Tree store for 7-joint configurations with linear nearest-node search.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_stall | req_type, joint_0..6, parent_index
// output  | out       | o_out_valid / i_out_stall | node_index, distance, path_cost, status
//
// One request at a time. A query scans all stored nodes, reading one node per
// cycle from the node memory; then the lane and merge pipeline drains, the
// cost memory is read and the square root unit runs. An insert runs the same
// path over one node, its parent; root set and rejected requests go straight
// to the finish state.
// Reset clears the node count and control state only; memories are not cleared.
// A finished beat waits in the output register while stalled; the next request
// is taken as soon as the block is back in idle.
// ----------------------------------------------------------------------------
module joint_tree_nearest_node
    import jtnn_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_req_type,
    input  logic signed [JOINT_W-1:0] i_joint_0,
    input  logic signed [JOINT_W-1:0] i_joint_1,
    input  logic signed [JOINT_W-1:0] i_joint_2,
    input  logic signed [JOINT_W-1:0] i_joint_3,
    input  logic signed [JOINT_W-1:0] i_joint_4,
    input  logic signed [JOINT_W-1:0] i_joint_5,
    input  logic signed [JOINT_W-1:0] i_joint_6,
    input  logic [IDX_W-1:0]          i_parent_index,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [IDX_W-1:0]          o_node_index,
    output logic [DIST_W-1:0]         o_distance,
    output logic [COST_W-1:0]         o_path_cost,
    output logic [1:0]                o_status
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    t_state            r_state, n_state;
    t_op               r_op;
    logic [1:0]        r_imm_status;
    t_joint_vec        r_query;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_addr;
    logic [CW-1:0]     r_last;
    logic              r_p1_valid, r_p2_valid;
    logic [AW-1:0]     r_p1_idx, r_p2_idx;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [DIST_W-1:0] r_out_dist;
    logic [COST_W-1:0] r_out_cost;
    logic [1:0]        r_out_status;

    logic              accept;
    logic              issue;
    logic              fin_go;
    logic              sqrt_start;
    logic              node_we;
    logic [AW-1:0]     node_waddr;
    t_joint_vec        node_rdata;
    logic [COST_W-1:0] cost_wdata;
    logic [COST_W-1:0] cost_rdata;
    t_sq_vec           lane_sq;
    logic              merge_busy;
    logic [AW-1:0]     best_idx;
    logic [SUM_W-1:0]  best_sq;
    logic              sqrt_busy;
    logic [ROOT_W-1:0] root;
    logic [DIST_W-1:0] dist_sat;
    logic [COST_W:0]   cost_sum;
    logic [COST_W-1:0] cost_sat;
    t_joint_vec        in_joints;

    assign in_joints = {i_joint_6, i_joint_5, i_joint_4, i_joint_3,
                        i_joint_2, i_joint_1, i_joint_0};

    assign o_in_stall = r_state != S_IDLE;
    assign accept     = i_in_valid && !o_in_stall;
    // the result register must be free or leaving this cycle
    assign fin_go     = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_QUERY && r_count != '0) begin
                        n_state = S_SCAN;
                    end else if (i_req_type == REQ_INSERT && r_count != '0
                                 && r_count < CW'(MAX_NODES)
                                 && 32'(i_parent_index) < 32'(r_count)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (r_addr == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1_valid && !r_p2_valid && !merge_busy) begin
                    n_state = S_COST;
                end
            end
            S_COST: n_state = S_SQRT;
            S_SQRT: begin
                if (!sqrt_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        issue      = 1'b0;
        sqrt_start = 1'b0;
        node_we    = 1'b0;
        node_waddr = r_count[AW-1:0];
        cost_wdata = cost_sat;
        case (r_state)
            S_SCAN: issue = 1'b1;
            S_COST: sqrt_start = 1'b1;
            S_FIN: begin
                if (fin_go && r_op == OP_ROOT) begin
                    node_we    = 1'b1;
                    node_waddr = '0;
                    cost_wdata = '0;
                end else if (fin_go && r_op == OP_INSERT) begin
                    node_we = 1'b1;
                end
            end
            default: issue = 1'b0;
        endcase
    end

    // saturate distance and accumulated cost
    assign dist_sat = (root > ROOT_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : root[DIST_W-1:0];
    assign cost_sum = (COST_W+1)'(cost_rdata) + (COST_W+1)'(dist_sat);
    assign cost_sat = cost_sum[COST_W] ? {COST_W{1'b1}} : cost_sum[COST_W-1:0];

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fin_go && r_op == OP_ROOT) begin
                r_count <= CW'(1);
            end else if (fin_go && r_op == OP_INSERT) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_p1_idx <= r_addr[AW-1:0];
        r_p2_idx <= r_p1_idx;
        if (issue) begin
            r_addr <= r_addr + 1'b1;
        end
        if (accept) begin
            r_query      <= in_joints;
            r_imm_status <= ST_OK;
            r_addr       <= CW'(i_parent_index);
            r_last       <= CW'(i_parent_index);
            case (i_req_type)
                REQ_ROOT: r_op <= OP_ROOT;
                REQ_INSERT: begin
                    r_op <= OP_INSERT;
                    if (r_count == '0) begin
                        r_op         <= OP_IMM;
                        r_imm_status <= ST_EMPTY;
                    end else if (r_count >= CW'(MAX_NODES)) begin
                        r_op         <= OP_IMM;
                        r_imm_status <= ST_FULL;
                    end else if (32'(i_parent_index) >= 32'(r_count)) begin
                        r_op         <= OP_IMM;
                        r_imm_status <= ST_BAD_PAR;
                    end
                end
                REQ_QUERY: begin
                    r_op   <= OP_QUERY;
                    r_addr <= '0;
                    r_last <= r_count - 1'b1;
                    if (r_count == '0) begin
                        r_op         <= OP_IMM;
                        r_imm_status <= ST_EMPTY;
                    end
                end
                default: r_op <= OP_IMM;
            endcase
        end
        if (fin_go) begin
            case (r_op)
                OP_INSERT: begin
                    r_out_idx    <= IDX_W'(r_count);
                    r_out_dist   <= dist_sat;
                    r_out_cost   <= cost_sat;
                    r_out_status <= ST_OK;
                end
                OP_QUERY: begin
                    r_out_idx    <= IDX_W'(best_idx);
                    r_out_dist   <= dist_sat;
                    r_out_cost   <= cost_rdata;
                    r_out_status <= ST_OK;
                end
                OP_ROOT: begin
                    r_out_idx    <= '0;
                    r_out_dist   <= '0;
                    r_out_cost   <= '0;
                    r_out_status <= ST_OK;
                end
                default: begin
                    r_out_idx    <= '0;
                    r_out_dist   <= '0;
                    r_out_cost   <= '0;
                    r_out_status <= r_imm_status;
                end
            endcase
        end
    end

    // ---------------- stores ----------------
    jtnn_ram #(.WIDTH(JOINTS*JOINT_W), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (r_query),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (node_rdata)
    );

    // read address follows the best node, which is the parent on insert
    jtnn_ram #(.WIDTH(COST_W), .DEPTH(MAX_NODES)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (cost_wdata),
        .i_raddr (best_idx),
        .o_rdata (cost_rdata)
    );

    // ---------------- lanes and merge ----------------
    for (genvar g = 0; g < JOINTS; g++) begin : g_lane
        jtnn_lane u_lane (
            .i_clk   (i_clk),
            .i_query (r_query[g]),
            .i_node  (node_rdata[g]),
            .o_sq    (lane_sq[g])
        );
    end

    jtnn_merge #(.AW(AW)) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (accept),
        .i_valid    (r_p2_valid),
        .i_idx      (r_p2_idx),
        .i_sq       (lane_sq),
        .o_busy     (merge_busy),
        .o_best_idx (best_idx),
        .o_best_sq  (best_sq)
    );

    jtnn_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sqrt_start),
        .i_operand (best_sq),
        .o_busy    (sqrt_busy),
        .o_root    (root)
    );

    assign o_out_valid  = r_out_valid;
    assign o_node_index = r_out_idx;
    assign o_distance   = r_out_dist;
    assign o_path_cost  = r_out_cost;
    assign o_status     = r_out_status;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_NODES))
        else $error("node count beyond capacity");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_addr <= r_last)
        else $error("scan address past last node");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result beat without finish");

    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |-> !sqrt_busy && !merge_busy)
        else $error("finish while units busy");

endmodule
